// ===== src/btr_pkg.sv =====
`timescale 1ns / 1ps

package btr_pkg;

	localparam int TEMPO_W      = 17;
	localparam int BARS_W       = 8;
	localparam int MODE_W       = 3;
	localparam int CNT_DEF_BITS = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 17;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLAY     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MUTE     = 3'd6;

	localparam int MODE_RAMP_EN  = 0;
	localparam int MODE_AUTO_REV = 1;
	localparam int MODE_MUTE_EN  = 2;

	typedef logic [TEMPO_W-1:0] tempo_t;
	typedef logic [BARS_W-1:0]  bars_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode_bits;
		bars_t             ramp_interval_bars;
		tempo_t            tempo_step;
		tempo_t            start_tempo;
		tempo_t            target_tempo;
		bars_t             play_len;
		bars_t             mute_len;
	} btr_cfg_t;

	typedef struct packed {
		logic ramp;
		logic mute;
		logic rising;
	} btr_reload_t;

	typedef struct packed {
		tempo_t tempo_out;
		logic   play_sound;
	} btr_result_t;

endpackage

// ===== src/btr_in_if.sv =====
`timescale 1ns / 1ps

interface btr_in_if import btr_pkg::*; ();
	logic   valid;
	logic   ready;
	tempo_t tempo_in;

	modport source (output valid, output tempo_in, input ready);
	modport sink (input valid, input tempo_in, output ready);
endinterface

// ===== src/btr_out_if.sv =====
`timescale 1ns / 1ps

interface btr_out_if import btr_pkg::*; ();
	logic   valid;
	logic   ready;
	tempo_t tempo_out;
	logic   play_sound;

	modport source (output valid, output tempo_out, output play_sound, input ready);
	modport sink (input valid, input tempo_out, input play_sound, output ready);
endinterface

// ===== src/btr_cfg_if.sv =====
`timescale 1ns / 1ps

interface btr_cfg_if import btr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/bar_tempo_ramp_and_mute_cycler.sv =====
`timescale 1ns / 1ps

// path: a bar_in beat reaches bar_out valid through the input register, then the result register
// throughput: one beat per cycle while bar_out is ready; tempo step, clamp and both bar counters resolve in one stage
// a full result register does not block input while the input register is free
// reset: config registers zero, bar counters zero, ramp direction rising, unmuted
module bar_tempo_ramp_and_mute_cycler import btr_pkg::*; #(
	parameter int BAR_COUNT_BITS = CNT_DEF_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	btr_in_if.sink     bar_in,
	btr_out_if.source  bar_out,
	btr_cfg_if.sink    cfg
);

	btr_cfg_t    cfg_q;
	btr_reload_t reload;
	btr_result_t res_d, res_s2;
	tempo_t      tempo_s1;
	logic        v_s1, v_s2;
	logic        s1_adv, in_acc;

	assign s1_adv       = v_s1 && (!v_s2 || bar_out.ready);
	assign bar_in.ready = !v_s1 || s1_adv;
	assign in_acc       = bar_in.valid && bar_in.ready;

	btr_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q),
		.reload (reload)
	);

	btr_step #(
		.BAR_COUNT_BITS (BAR_COUNT_BITS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_q    (cfg_q),
		.reload   (reload),
		.advance  (s1_adv),
		.tempo_in (tempo_s1),
		.result   (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (bar_in.ready) begin
				v_s1 <= bar_in.valid;
			end
			if (s1_adv) begin
				v_s2 <= 1'b1;
			end else if (bar_out.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tempo_s1 <= bar_in.tempo_in;
		end
		if (s1_adv) begin
			res_s2 <= res_d;
		end
	end

	assign bar_out.valid      = v_s2;
	assign bar_out.tempo_out  = res_s2.tempo_out;
	assign bar_out.play_sound = res_s2.play_sound;

	a_in_lands_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> v_s1)
		else $error("accepted beat not held in input register");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> v_s2)
		else $error("input register advanced without result");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && bar_out.ready && !v_s1 |=> !v_s2)
		else $error("result register not emptied");

endmodule

// ===== src/btr_regs.sv =====
`timescale 1ns / 1ps

module btr_regs import btr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	btr_cfg_if.sink     cfg,
	output btr_cfg_t    cfg_q,
	output btr_reload_t reload
);

	logic   wr;
	tempo_t new_start;
	tempo_t new_target;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;

	assign new_start  = (cfg.index == REG_START) ? cfg.data[TEMPO_W-1:0] : cfg_q.start_tempo;
	assign new_target = (cfg.index == REG_TARGET) ? cfg.data[TEMPO_W-1:0] : cfg_q.target_tempo;

	always_comb begin
		reload.ramp   = 1'b0;
		reload.mute   = 1'b0;
		reload.rising = (new_target >= new_start);
		if (wr) begin
			unique case (cfg.index) inside
				REG_MODE: begin
					reload.ramp = 1'b1;
					reload.mute = 1'b1;
				end
				REG_INTERVAL, REG_STEP, REG_START, REG_TARGET: begin
					reload.ramp = 1'b1;
				end
				REG_PLAY, REG_MUTE: begin
					reload.mute = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (cfg.index)
				REG_MODE:     cfg_q.mode_bits          <= cfg.data[MODE_W-1:0];
				REG_INTERVAL: cfg_q.ramp_interval_bars <= cfg.data[BARS_W-1:0];
				REG_STEP:     cfg_q.tempo_step         <= cfg.data[TEMPO_W-1:0];
				REG_START:    cfg_q.start_tempo        <= cfg.data[TEMPO_W-1:0];
				REG_TARGET:   cfg_q.target_tempo       <= cfg.data[TEMPO_W-1:0];
				REG_PLAY:     cfg_q.play_len           <= cfg.data[BARS_W-1:0];
				REG_MUTE:     cfg_q.mute_len           <= cfg.data[BARS_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/btr_step.sv =====
`timescale 1ns / 1ps

module btr_step import btr_pkg::*; #(
	parameter int BAR_COUNT_BITS = CNT_DEF_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  btr_cfg_t    cfg_q,
	input  btr_reload_t reload,
	input  logic        advance,
	input  tempo_t      tempo_in,
	output btr_result_t result
);

	localparam int CMP_W = (BAR_COUNT_BITS > BARS_W) ? BAR_COUNT_BITS : BARS_W;

	logic [BAR_COUNT_BITS-1:0] ramp_cnt_q, ramp_cnt_inc, ramp_cnt_d;
	logic [BAR_COUNT_BITS-1:0] mute_cnt_q, mute_cnt_inc, mute_cnt_d;
	logic                      rising_q, rising_d;
	logic                      muted_q, muted_d;

	logic               ramp_on, fire, hit_top, hit_bot;
	logic [TEMPO_W:0]   sum, lo_bound;
	tempo_t             tempo_d;
	logic               mute_en, mute_fire;
	bars_t              mute_lim;

	assign ramp_cnt_inc = ramp_cnt_q + 1'b1;
	assign ramp_on      = cfg_q.mode_bits[MODE_RAMP_EN] && (cfg_q.ramp_interval_bars != '0);
	assign fire         = ramp_on && (CMP_W'(ramp_cnt_inc) >= CMP_W'(cfg_q.ramp_interval_bars));

	assign sum      = {1'b0, tempo_in} + {1'b0, cfg_q.tempo_step};
	assign lo_bound = {1'b0, cfg_q.tempo_step} + {1'b0, cfg_q.start_tempo};
	assign hit_top  = (sum >= {1'b0, cfg_q.target_tempo});
	assign hit_bot  = ({1'b0, tempo_in} <= lo_bound);

	always_comb begin
		tempo_d  = tempo_in;
		rising_d = rising_q;
		if (fire) begin
			if (rising_q) begin
				tempo_d = hit_top ? cfg_q.target_tempo : sum[TEMPO_W-1:0];
				if (hit_top && cfg_q.mode_bits[MODE_AUTO_REV]) begin
					rising_d = 1'b0;
				end
			end else begin
				tempo_d = hit_bot ? cfg_q.start_tempo : (tempo_in - cfg_q.tempo_step);
				if (hit_bot && cfg_q.mode_bits[MODE_AUTO_REV]) begin
					rising_d = 1'b1;
				end
			end
		end
	end

	assign ramp_cnt_d = !ramp_on ? ramp_cnt_q : (fire ? '0 : ramp_cnt_inc);

	assign mute_en      = cfg_q.mode_bits[MODE_MUTE_EN];
	assign mute_cnt_inc = mute_cnt_q + 1'b1;
	assign mute_lim     = muted_q ? cfg_q.mute_len : cfg_q.play_len;
	assign mute_fire    = (CMP_W'(mute_cnt_inc) >= CMP_W'(mute_lim));
	assign muted_d      = mute_en && (mute_fire ? !muted_q : muted_q);
	assign mute_cnt_d   = !mute_en ? mute_cnt_q : (mute_fire ? '0 : mute_cnt_inc);

	assign result.tempo_out  = tempo_d;
	assign result.play_sound = !muted_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_cnt_q <= '0;
			rising_q   <= 1'b1;
			mute_cnt_q <= '0;
			muted_q    <= 1'b0;
		end else begin
			if (reload.ramp) begin
				ramp_cnt_q <= '0;
				rising_q   <= reload.rising;
			end else if (advance) begin
				ramp_cnt_q <= ramp_cnt_d;
				rising_q   <= rising_d;
			end
			if (reload.mute) begin
				mute_cnt_q <= '0;
				muted_q    <= 1'b0;
			end else if (advance) begin
				mute_cnt_q <= mute_cnt_d;
				muted_q    <= muted_d;
			end
		end
	end

	a_ramp_cnt_below_interval: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_on |-> (CMP_W'(ramp_cnt_q) < CMP_W'(cfg_q.ramp_interval_bars)))
		else $error("ramp bar count reached interval");

	a_unmuted_when_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		!mute_en |-> !muted_q)
		else $error("muted while mute cycling disabled");

	a_rising_reload: assert property (@(posedge clk) disable iff (!arst_n)
		reload.ramp |=> (rising_q == $past(reload.rising)) && (ramp_cnt_q == '0))
		else $error("ramp direction not reloaded");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import btr_pkg::*;

	localparam int CNT_BITS = CNT_DEF_BITS;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam int TEMPO_MAX = 100000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int MODE_RAMP = 1 << MODE_RAMP_EN;
	localparam int MODE_ALL = (1 << MODE_RAMP_EN) | (1 << MODE_AUTO_REV) | (1 << MODE_MUTE_EN);

	typedef struct {
		bit     follow;
		tempo_t tempo;
	} bar_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	btr_in_if  bar_if ();
	btr_out_if res_if ();
	btr_cfg_if cfg_if ();

	bar_tempo_ramp_and_mute_cycler #(.BAR_COUNT_BITS(CNT_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.bar_in(bar_if),
		.bar_out(res_if),
		.cfg(cfg_if)
	);

	// shadow of the block
	btr_cfg_t            regs;
	logic [CNT_BITS-1:0] ramp_cnt;
	logic [CNT_BITS-1:0] mute_cnt;
	logic                climbing;
	logic                silent;

	bar_item_t   bars_to_send [$];
	btr_result_t predicted_bars [$];
	btr_result_t last_out = '0;

	bit gaps_on = 1'b1;
	int src_gap, sink_gap, hold_left;
	int squeeze_req, squeeze_done;
	int bars_queued, bars_accepted, results_checked;
	int settings_seen, ramp_steps, muted_bars;
	int errors;
	int quiet;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void reload_ramp();
		ramp_cnt = '0;
		climbing = regs.target_tempo >= regs.start_tempo;
	endfunction

	function automatic void reload_mute();
		mute_cnt = '0;
		silent = 1'b0;
	endfunction

	function automatic btr_result_t advance_bar(tempo_t tempo_in);
		logic [TEMPO_W:0] sum;
		int               diff;
		tempo_t           tp;
		btr_result_t      r;
		tp = tempo_in;
		if (regs.mode_bits[MODE_RAMP_EN] && regs.ramp_interval_bars != '0) begin
			ramp_cnt = ramp_cnt + 1'b1;
			if (ramp_cnt >= regs.ramp_interval_bars) begin
				ramp_cnt = '0;
				ramp_steps++;
				if (climbing) begin
					sum = {1'b0, tp} + {1'b0, regs.tempo_step};
					if (sum >= {1'b0, regs.target_tempo}) begin
						tp = regs.target_tempo;
						if (regs.mode_bits[MODE_AUTO_REV])
							climbing = 1'b0;
					end else begin
						tp = sum[TEMPO_W-1:0];
					end
				end else begin
					diff = int'(tp) - int'(regs.tempo_step);
					if (diff <= int'(regs.start_tempo)) begin
						tp = regs.start_tempo;
						if (regs.mode_bits[MODE_AUTO_REV])
							climbing = 1'b1;
					end else begin
						tp = diff[TEMPO_W-1:0];
					end
				end
			end
		end
		if (regs.mode_bits[MODE_MUTE_EN]) begin
			mute_cnt = mute_cnt + 1'b1;
			if (mute_cnt >= (silent ? regs.mute_len : regs.play_len)) begin
				silent = !silent;
				mute_cnt = '0;
			end
		end else begin
			silent = 1'b0;
		end
		if (silent)
			muted_bars++;
		r.tempo_out = tp;
		r.play_sound = !silent;
		return r;
	endfunction

	// bar source
	always @(posedge clk or negedge arst_n) begin
		bar_item_t nxt;
		logic      busy;
		if (!arst_n) begin
			bar_if.valid <= 1'b0;
			bar_if.tempo_in <= '0;
			src_gap = 0;
		end else begin
			busy = bar_if.valid;
			if (bar_if.valid && bar_if.ready) begin
				last_out = advance_bar(bar_if.tempo_in);
				predicted_bars.push_back(last_out);
				bars_accepted++;
				busy = 1'b0;
				if (gaps_on && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 17);
			end
			if (!busy) begin
				if (src_gap > 0) begin
					src_gap--;
					bar_if.valid <= 1'b0;
				end else if (bars_to_send.size() > 0) begin
					nxt = bars_to_send.pop_front();
					bar_if.valid <= 1'b1;
					bar_if.tempo_in <= nxt.follow ? last_out.tempo_out : nxt.tempo;
				end else begin
					bar_if.valid <= 1'b0;
				end
			end
		end
	end

	// result sink and checker
	always @(posedge clk or negedge arst_n) begin
		btr_result_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			sink_gap = 0;
			hold_left = 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				results_checked++;
				if (predicted_bars.size() == 0) begin
					$error("unexpected beat: tempo_out %0d play_sound %0b",
						res_if.tempo_out, res_if.play_sound);
					errors++;
				end else begin
					want = predicted_bars.pop_front();
					if (res_if.tempo_out !== want.tempo_out) begin
						$error("tempo_out: expected %0d, got %0d", want.tempo_out, res_if.tempo_out);
						errors++;
					end
					if (res_if.play_sound !== want.play_sound) begin
						$error("play_sound: expected %0b, got %0b", want.play_sound,
							res_if.play_sound);
						errors++;
					end
				end
				if (gaps_on && $urandom_range(0, 5) == 0)
					sink_gap = $urandom_range(1, 17);
			end
			if (squeeze_req != squeeze_done) begin
				squeeze_done = squeeze_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (bar_if.valid && bar_if.ready) || (res_if.valid && res_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb: stuck for %0d cycles with %0d results outstanding", quiet,
					predicted_bars.size());
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		case (idx)
			REG_MODE: begin
				regs.mode_bits = val[MODE_W-1:0];
				reload_ramp();
				reload_mute();
			end
			REG_INTERVAL: begin
				regs.ramp_interval_bars = val[BARS_W-1:0];
				reload_ramp();
			end
			REG_STEP: begin
				regs.tempo_step = val[TEMPO_W-1:0];
				reload_ramp();
			end
			REG_START: begin
				regs.start_tempo = val[TEMPO_W-1:0];
				reload_ramp();
			end
			REG_TARGET: begin
				regs.target_tempo = val[TEMPO_W-1:0];
				reload_ramp();
			end
			REG_PLAY: begin
				regs.play_len = val[BARS_W-1:0];
				reload_mute();
			end
			REG_MUTE: begin
				regs.mute_len = val[BARS_W-1:0];
				reload_mute();
			end
			default: ;
		endcase
	endtask

	task automatic queue_bar(input bit follow, input int tempo);
		bar_item_t it;
		it.follow = follow;
		it.tempo = tempo_t'(tempo);
		bars_to_send.push_back(it);
		bars_queued++;
	endtask

	task automatic settle();
		while (bars_accepted != bars_queued || predicted_bars.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase(input int n_bars, input bit all_regs);
		logic [CFG_IDX_W-1:0] order [7];
		logic [CFG_IDX_W-1:0] tmp;
		int                   j;
		int                   val;
		int                   written;
		order = '{REG_MODE, REG_INTERVAL, REG_STEP, REG_START, REG_TARGET, REG_PLAY, REG_MUTE};
		for (int i = 6; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		written = 0;
		for (int i = 0; i < 7; i++) begin
			if (all_regs || $urandom_range(0, 1) == 1 || (i == 6 && written == 0)) begin
				case (order[i])
					REG_MODE:
						val = $urandom_range(0, 7) | ($urandom_range(0, 3) != 0 ? MODE_RAMP : 0);
					REG_INTERVAL, REG_PLAY, REG_MUTE:
						case ($urandom_range(0, 9))
							0: val = 0;
							1: val = 255;
							default: val = $urandom_range(1, 4);
						endcase
					REG_STEP:
						case ($urandom_range(0, 5))
							0: val = 0;
							1: val = TEMPO_MAX;
							2: val = $urandom_range(0, TEMPO_MAX);
							default: val = $urandom_range(1, 20000);
						endcase
					default:
						case ($urandom_range(0, 5))
							0: val = 0;
							1: val = TEMPO_MAX;
							default: val = $urandom_range(0, TEMPO_MAX);
						endcase
				endcase
				write_reg(order[i], val);
				written++;
			end
		end
		if ($urandom_range(0, 7) == 0)
			write_reg(REG_UNUSED, $urandom_range(0, TEMPO_MAX));
		settings_seen++;
		for (int i = 0; i < n_bars; i++) begin
			if ($urandom_range(0, 4) != 0)
				queue_bar(1'b1, 0);
			else
				case ($urandom_range(0, 9))
					0: queue_bar(1'b0, 0);
					1: queue_bar(1'b0, TEMPO_MAX);
					default: queue_bar(1'b0, $urandom_range(0, TEMPO_MAX));
				endcase
		end
	endtask

	initial begin
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_MODE;
		cfg_if.data = '0;
		regs = '0;
		reload_ramp();
		reload_mute();
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset values: ramp and mute off, tempo passes through
		settings_seen++;
		queue_bar(1'b0, 0);
		queue_bar(1'b0, TEMPO_MAX);
		queue_bar(1'b0, 65535);
		settle();

		// step every bar, auto reverse, zero play and mute counts
		write_reg(REG_MODE, MODE_ALL);
		write_reg(REG_INTERVAL, 1);
		write_reg(REG_STEP, 1000);
		write_reg(REG_START, 1000);
		write_reg(REG_TARGET, 5000);
		write_reg(REG_PLAY, 0);
		write_reg(REG_MUTE, 0);
		write_reg(REG_UNUSED, 12345);
		settings_seen++;
		queue_bar(1'b0, 4500);
		queue_bar(1'b0, 2000);
		queue_bar(1'b0, 0);
		queue_bar(1'b0, 1000);
		queue_bar(1'b0, 4000);
		queue_bar(1'b1, 0);
		queue_bar(1'b1, 0);
		settle();

		// overshoot at full width, no reverse
		write_reg(REG_MODE, MODE_RAMP);
		write_reg(REG_INTERVAL, 2);
		write_reg(REG_STEP, TEMPO_MAX);
		write_reg(REG_START, 50000);
		write_reg(REG_TARGET, TEMPO_MAX);
		settings_seen++;
		queue_bar(1'b0, TEMPO_MAX);
		queue_bar(1'b0, TEMPO_MAX);
		queue_bar(1'b0, 0);
		queue_bar(1'b0, 0);
		settle();

		// crossed bounds start falling, difference below zero
		write_reg(REG_START, TEMPO_MAX);
		write_reg(REG_TARGET, 0);
		settings_seen++;
		queue_bar(1'b0, 0);
		queue_bar(1'b0, 0);
		queue_bar(1'b0, 99999);
		queue_bar(1'b0, TEMPO_MAX);
		settle();

		// mode and bar counts at their top values, tempo registers at TEMPO_MAX
		write_reg(REG_MODE, MODE_ALL);
		write_reg(REG_INTERVAL, 255);
		write_reg(REG_STEP, TEMPO_MAX);
		write_reg(REG_START, TEMPO_MAX);
		write_reg(REG_TARGET, TEMPO_MAX);
		write_reg(REG_PLAY, 255);
		write_reg(REG_MUTE, 255);
		settings_seen++;
		for (int i = 0; i < 20; i++)
			queue_bar(1'b1, 0);
		settle();

		for (int p = 0; p < 9; p++) begin
			gaps_on = p < 6 && p != 3;
			random_phase(p == 8 ? 30 : 45, p == 0 || p == 6);
			if (p == 3)
				squeeze_req++;
			settle();
		end

		repeat (8) @(posedge clk);
		if (predicted_bars.size() != 0) begin
			$error("%0d results never arrived", predicted_bars.size());
			errors++;
		end
		$display("tb: %0d bars over %0d register settings, %0d results checked",
			bars_accepted, settings_seen, results_checked);
		$display("tb: %0d tempo steps taken, %0d bars muted", ramp_steps, muted_bars);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
